// ===== src/slms_pkg.sv =====
// Package for the scrolling LED matrix scanner: payload structs, queue entry,
// operation and register codes, and the row select helper.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package slms_pkg;

   // Matrix geometry and frame constants
   localparam int ROWS              = 7;
   localparam int ROW_W             = $clog2(ROWS);
   localparam int TIME_W            = 9;
   localparam int PATTERN_DEPTH_DEF = 1024;
   localparam int PICTURE_SLOTS_DEF = 16;
   localparam int END_OFFSET        = ROWS - 1;
   localparam logic [7:0] END_MARK            = 8'hff;
   localparam logic [7:0] FRAME_RESET         = 8'd125;
   localparam logic [4:0] PICTURE_COUNT_RESET = 5'd1;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Register file
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PICTURE_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_MS      = 2'd1;

   typedef enum logic [1:0] {
      OP_WRITE_PATTERN = 2'd0,
      OP_WRITE_START   = 2'd1,
      OP_TICK          = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CMD_PATTERN = 2'd0,
      CMD_START   = 2'd1,
      CMD_TICK    = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [9:0] address;
      logic [7:0] pattern_byte;
      logic [3:0] slot;
      logic       button_down;
   } req_type;

   typedef struct packed {
      logic [ROWS-1:0] row_drive;
      logic [7:0]      column_drive;
      logic [3:0]      picture_number;
      logic            picture_changed;
   } rsp_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [9:0] address;
      logic [7:0] pattern_byte;
      logic [3:0] slot;
      logic       button_down;
   } cmd_entry_type;

   // Active-low row select: all ones but a zero at the driven row
   function automatic logic [ROWS-1:0] row_select(input logic [ROW_W-1:0] row);
      return ~(ROWS'(1) << row);
   endfunction

endpackage

`default_nettype wire

// ===== src/slms_front.sv =====
// Front end of the scanner: takes requests, drops undefined operations and
// queues the rest as commands for the back end. Uses slms_pkg.
`default_nettype none

module slms_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire slms_pkg::req_type      req_payload,
   output logic                        cmd_valid,
   input  wire logic                   cmd_ready,
   output slms_pkg::cmd_entry_type     cmd
);
   import slms_pkg::*;

   cmd_entry_type           queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]         count_ff, count_in;
   logic                    known_op;
   logic                    push, pop;
   cmd_entry_type           entry;

   // Classify the request
   always_comb begin
      known_op           = 1'b1;
      entry.cmd          = CMD_TICK;
      entry.address      = req_payload.address;
      entry.pattern_byte = req_payload.pattern_byte;
      entry.slot         = req_payload.slot;
      entry.button_down  = req_payload.button_down;
      case (req_payload.operation)
         OP_WRITE_PATTERN: entry.cmd = CMD_PATTERN;
         OP_WRITE_START:   entry.cmd = CMD_START;
         OP_TICK:          entry.cmd = CMD_TICK;
         default:          known_op  = 1'b0;
      endcase
   end

   assign req_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

   assign push = req_valid && req_ready && known_op;
   assign pop  = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

`default_nettype wire

// ===== src/slms_back.sv =====
// Back end of the scanner: pattern and start memories, scan and scroll
// state, button lockout and the response register. Uses slms_pkg.
`default_nettype none

module slms_back #(
   parameter int PATTERN_DEPTH = slms_pkg::PATTERN_DEPTH_DEF,
   parameter int PICTURE_SLOTS = slms_pkg::PICTURE_SLOTS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   cmd_valid,
   output logic                        cmd_ready,
   input  wire slms_pkg::cmd_entry_type cmd,
   input  wire logic [4:0]             picture_count,
   input  wire logic [7:0]             frame_ms,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output slms_pkg::rsp_type           rsp_payload
);
   import slms_pkg::*;

   localparam int AW    = $clog2(PATTERN_DEPTH);
   localparam int SW    = $clog2(PICTURE_SLOTS);
   localparam int CNT_W = ($clog2(PICTURE_SLOTS + 1) > 5) ? $clog2(PICTURE_SLOTS + 1) : 5;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_COL  = 4'b0010,
      ST_SENT = 4'b0100,
      ST_PIC  = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [3:0]                pic_ff, pic_in;
   logic [AW-1:0]             wb_ff, wb_in;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic signed [TIME_W-1:0]  time_ff, time_in;
   logic                      lock_ff, lock_in;
   logic [9:0]                start_ff, start_in;
   logic [7:0]                col_ff, col_in;
   logic                      btn_ff, btn_in;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff, rsp_in;

   logic [7:0]                pattern_mem [PATTERN_DEPTH];
   logic [9:0]                start_mem [PICTURE_SLOTS];
   logic [7:0]                pat_rd_ff;
   logic [9:0]                st_rd_ff;
   logic                      pat_we, pat_re, st_we, st_re;
   logic [AW-1:0]             pat_addr;
   logic [SW-1:0]             st_waddr, st_raddr;

   logic                      out_free, emit;
   logic                      scan_end, press, timeout;
   logic signed [TIME_W-1:0]  tl_dec, reload;
   logic [CNT_W-1:0]          pic_limit, pic_plus;
   logic [3:0]                next_pic;

   // Fold a slot number into the start table by repeated subtraction
   function automatic logic [SW-1:0] slot_index(input logic [3:0] s);
      logic [6:0] v;
      v = {3'b000, s};
      for (int i = 0; i < 8; i++) begin
         if (v >= 7'(PICTURE_SLOTS)) begin
            v = v - 7'(PICTURE_SLOTS);
         end
      end
      return SW'(v);
   endfunction

   assign cmd_ready   = (state_ff == ST_IDLE);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Scan-end decisions
   always_comb begin
      scan_end = (row_ff == ROW_W'(ROWS - 1));
      tl_dec   = time_ff - TIME_W'(ROWS);
      reload   = (frame_ms == 8'd0) ? TIME_W'(1) : TIME_W'(frame_ms);
      press    = scan_end && btn_ff && !lock_ff;
      timeout  = scan_end && !press && (tl_dec <= 0);
      if (picture_count == 5'd0) begin
         pic_limit = CNT_W'(1);
      end else if (CNT_W'(picture_count) > CNT_W'(PICTURE_SLOTS)) begin
         pic_limit = CNT_W'(PICTURE_SLOTS);
      end else begin
         pic_limit = CNT_W'(picture_count);
      end
      pic_plus = CNT_W'(pic_ff) + CNT_W'(1);
      next_pic = (pic_plus >= pic_limit) ? 4'd0 : 4'(pic_plus);
   end

   always_comb begin
      state_in = state_ff;
      pic_in   = pic_ff;
      wb_in    = wb_ff;
      row_in   = row_ff;
      time_in  = time_ff;
      lock_in  = lock_ff;
      start_in = start_ff;
      col_in   = col_ff;
      btn_in   = btn_ff;
      pat_we   = 1'b0;
      pat_re   = 1'b0;
      st_we    = 1'b0;
      st_re    = 1'b0;
      pat_addr = AW'(start_ff) + wb_ff + AW'(row_ff);
      st_waddr = slot_index(cmd.slot);
      st_raddr = SW'(next_pic);
      emit     = 1'b0;
      rsp_in.row_drive       = row_select(ROW_W'(ROWS - 1));
      rsp_in.column_drive    = col_ff;
      rsp_in.picture_number  = pic_ff;
      rsp_in.picture_changed = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.cmd)
                  CMD_PATTERN: begin
                     pat_we   = 1'b1;
                     pat_addr = AW'(cmd.address);
                  end
                  CMD_START: begin
                     st_we = 1'b1;
                     // keep the shown picture's start in step with the table
                     if (st_waddr == SW'(pic_ff)) begin
                        start_in = cmd.address;
                     end
                  end
                  CMD_TICK: begin
                     pat_re   = 1'b1;
                     btn_in   = cmd.button_down;
                     state_in = ST_COL;
                  end
                  default: ;
               endcase
            end
         end
         ST_COL: begin
            if (press) begin
               pic_in   = next_pic;
               wb_in    = '0;
               time_in  = reload;
               lock_in  = 1'b1;
               row_in   = '0;
               col_in   = pat_rd_ff;
               st_re    = 1'b1;
               state_in = ST_PIC;
            end else if (timeout) begin
               // advance the window, then look for the end mark
               wb_in    = wb_ff + AW'(1);
               time_in  = reload;
               lock_in  = lock_ff && btn_ff;
               row_in   = '0;
               col_in   = pat_rd_ff;
               pat_re   = 1'b1;
               pat_addr = AW'(start_ff) + wb_ff + AW'(END_OFFSET + 1);
               state_in = ST_SENT;
            end else if (out_free) begin
               emit                = 1'b1;
               rsp_in.row_drive    = row_select(row_ff);
               rsp_in.column_drive = pat_rd_ff;
               row_in   = scan_end ? '0 : row_ff + ROW_W'(1);
               if (scan_end) begin
                  time_in = tl_dec;
                  lock_in = lock_ff && btn_ff;
               end
               state_in = ST_IDLE;
            end
         end
         ST_SENT: begin
            if (out_free) begin
               emit = 1'b1;
               if (pat_rd_ff == END_MARK) begin
                  wb_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_PIC: begin
            if (out_free) begin
               emit                   = 1'b1;
               rsp_in.picture_changed = 1'b1;
               start_in               = st_rd_ff;
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pic_ff       <= '0;
         wb_ff        <= '0;
         row_ff       <= '0;
         time_ff      <= TIME_W'(FRAME_RESET);
         lock_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pic_ff   <= pic_in;
         wb_ff    <= wb_in;
         row_ff   <= row_in;
         time_ff  <= time_in;
         lock_ff  <= lock_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      col_ff   <= col_in;
      btn_ff   <= btn_in;
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pat_we) begin
         pattern_mem[pat_addr] <= cmd.pattern_byte;
      end
      if (pat_re) begin
         pat_rd_ff <= pattern_mem[pat_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         start_mem[st_waddr] <= cmd.address;
      end
      if (st_re) begin
         st_rd_ff <= start_mem[st_raddr];
      end
   end

endmodule

`default_nettype wire

// ===== src/scrolling_led_matrix_scanner_top.sv =====
// Flow: a tick request reads the pattern memory, then loads the response
//   register; a tick that ends a scan and scrolls the window or switches
//   picture first makes a second read (pattern or start memory). The back
//   end takes no new command until that response is issued, and a stalled
//   response holds it. Undefined operations are dropped.
// Reset: synchronous, active high; clears control state, the queue, the
//   response valid and restores picture_count to 1 and frame_ms to 125.
`default_nettype none

module scrolling_led_matrix_scanner_top #(
   parameter int PATTERN_DEPTH = slms_pkg::PATTERN_DEPTH_DEF,
   parameter int PICTURE_SLOTS = slms_pkg::PICTURE_SLOTS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire slms_pkg::req_type                     req_payload,
   // response channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output slms_pkg::rsp_type                          rsp_payload,
   // register writes
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [slms_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [7:0]                            csr_data
);
   import slms_pkg::*;

   logic [4:0]     picture_count_ff;
   logic [7:0]     frame_ms_ff;
   logic           cmd_valid;
   logic           cmd_ready;
   cmd_entry_type  cmd;

   // Registers are to be written only while the block is idle; the block does not enforce this, so accept always.
   assign csr_ready = 1'b1;

   // Hold the configuration; ignore writes to indexes that name no register.
   always_ff @(posedge clock) begin
      if (reset) begin
         picture_count_ff <= PICTURE_COUNT_RESET;
         frame_ms_ff      <= FRAME_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PICTURE_COUNT: picture_count_ff <= csr_data[4:0];
            CSR_FRAME_MS:      frame_ms_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // Front: accept and classify requests, queue them for the back end.
   slms_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd)
   );

   // Back: execute loads and ticks, drive the response register.
   slms_back #(
      .PATTERN_DEPTH (PATTERN_DEPTH),
      .PICTURE_SLOTS (PICTURE_SLOTS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd_ready     (cmd_ready),
      .cmd           (cmd),
      .picture_count (picture_count_ff),
      .frame_ms      (frame_ms_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== src/slms_checker.sv =====
// Port-level checks on the scanner's response channel, bound to the top level.
// Uses slms_pkg.
`default_nettype none

module slms_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire slms_pkg::rsp_type rsp_payload
);
   import slms_pkg::*;

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped or changed while stalled");

   // Drive exactly one row
   a_one_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones(~rsp_payload.row_drive) == 1)
      else $error("row drive does not select exactly one row");

   // Switch picture only on the last row of a scan
   a_switch_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.picture_changed |->
         rsp_payload.row_drive == row_select(ROW_W'(ROWS - 1)))
      else $error("picture switched away from the end of a scan");

   // Come out of reset with no response pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind scrolling_led_matrix_scanner_top slms_checker u_slms_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for the scrolling LED matrix scanner: request driver, response monitor,
// register writer and a request-level predictor of the scan, scroll and picture switch logic.
// Depends on slms_pkg and scrolling_led_matrix_scanner_top.
`timescale 1ns / 1ps

module tb_top;
   import slms_pkg::*;

   // Operation code that the block must drop, and a register index it must ignore
   localparam logic [1:0] OP_UNDEFINED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 80;
   localparam int SETTLE_CYCLES = 8;
   localparam int STUCK_LIMIT   = 1000;
   localparam int REPORT_CAP    = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid   = 1'b0;
   logic       req_ready;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   rsp_type    rsp_payload;
   logic       csr_valid   = 1'b0;
   logic       csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0] csr_data    = '0;

   scrolling_led_matrix_scanner_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Scanner predictor state: its own copy of the stores, the scan
   // position, the frame timer and both registers.
   // ------------------------------------------------------------------
   logic [7:0]        pattern_mem [1024];
   logic [9:0]        start_addr  [16];
   logic [3:0]        shown_picture;
   logic [9:0]        window_off;
   logic [2:0]        scan_row;
   logic signed [8:0] frame_left;
   logic              press_lock;
   logic [4:0]        picture_count_reg;
   logic [7:0]        frame_ms_reg;

   rsp_type row_outputs_due [$];   // predicted row outputs, oldest first
   req_type req_backlog [$];       // requests waiting for the driver

   int  req_queued     = 0;
   int  req_taken      = 0;
   int  ticks_queued   = 0;
   int  mismatch_count = 0;
   int  send_gap       = 0;
   int  stall_left     = 0;
   int  stuck_cycles   = 0;
   bit  quiet          = 1'b0;     // no idling on either side when set

   task automatic clear_scanner();
      shown_picture     = '0;
      window_off        = '0;
      scan_row          = '0;
      frame_left        = 9'sd125;
      press_lock        = 1'b0;
      picture_count_reg = PICTURE_COUNT_RESET;
      frame_ms_reg      = FRAME_RESET;
   endtask

   // Advance the predictor by one accepted request; a tick queues one row output.
   task automatic step_scanner(input req_type r);
      rsp_type           row_out;
      logic [2:0]        row;
      logic [4:0]        wrap_at;
      logic              switched;
      logic signed [8:0] reload;
      reload = (frame_ms_reg == 8'd0) ? 9'sd1 : $signed({1'b0, frame_ms_reg});
      case (r.operation)
         OP_WRITE_PATTERN: pattern_mem[r.address] = r.pattern_byte;
         OP_WRITE_START:   start_addr[r.slot] = r.address;
         OP_TICK: begin
            row      = scan_row;
            switched = 1'b0;
            row_out.row_drive    = ~(7'd1 << row);
            row_out.column_drive = pattern_mem[10'(start_addr[shown_picture] + window_off + row)];
            if (row == 3'(ROWS - 1)) begin
               // End of a full scan: charge the frame, then look at the button
               scan_row   = '0;
               frame_left = frame_left - 9'sd7;
               if (!r.button_down) begin
                  press_lock = 1'b0;
               end else if (!press_lock) begin
                  // Clamp the wrap point to 1..16
                  if (picture_count_reg == 5'd0)
                     wrap_at = 5'd1;
                  else if (picture_count_reg > 5'd16)
                     wrap_at = 5'd16;
                  else
                     wrap_at = picture_count_reg;
                  shown_picture = ({1'b0, shown_picture} + 5'd1 >= wrap_at) ? 4'd0
                                                                             : shown_picture + 4'd1;
                  window_off = '0;
                  frame_left = reload;
                  press_lock = 1'b1;
                  switched   = 1'b1;
               end
               // Scroll only if no press took over this scan
               if (!switched && frame_left <= 9'sd0) begin
                  window_off = window_off + 10'd1;
                  if (pattern_mem[10'(start_addr[shown_picture] + window_off + END_OFFSET)]
                      == END_MARK)
                     window_off = '0;
                  frame_left = reload;
               end
            end else begin
               scan_row = row + 3'd1;
            end
            row_out.picture_number  = shown_picture;
            row_out.picture_changed = switched;
            row_outputs_due.push_back(row_out);
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < REPORT_CAP)
         $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
      mismatch_count++;
   endtask

   task automatic queue_request(input logic [1:0] op, input logic [9:0] addr,
                                input logic [7:0] pbyte, input logic [3:0] slot,
                                input logic btn);
      req_type r;
      r.operation    = op;
      r.address      = addr;
      r.pattern_byte = pbyte;
      r.slot         = slot;
      r.button_down  = btn;
      req_backlog.push_back(r);
      req_queued++;
      if (op == OP_TICK)
         ticks_queued++;
   endtask

   // Hold until every request is taken and every row output has come back,
   // then let the pipeline settle after writes that produce nothing.
   task automatic wait_idle();
      while (req_taken != req_queued || row_outputs_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register; only called while the block is idle.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] value);
      @(posedge clock);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      // Accepted at this edge: mirror it in the predictor
      case (idx)
         CSR_PICTURE_COUNT: picture_count_reg = value[4:0];
         CSR_FRAME_MS:      frame_ms_reg = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Request driver: pop the backlog, hold valid and payload until the
   // request is taken, and insert random idle bursts.
   // Valid gets one assignment per edge, so back-to-back requests keep
   // it high and only swap the payload.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
         clear_scanner();
      end else begin
         if (req_valid && req_ready) begin
            step_scanner(req_payload);
            req_taken++;
         end
         if (req_valid && !req_ready) begin
            // hold the current request
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (req_backlog.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 3);
            req_valid <= 1'b0;
         end else begin
            req_payload <= req_backlog.pop_front();
            req_valid   <= 1'b1;
         end
      end
   end

   // Response side backpressure: random stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Response monitor: compare each taken response with the oldest prediction
   always @(posedge clock) begin : response_monitor
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (row_outputs_due.size() == 0) begin
            report_mismatch("response with nothing due", 32'(rsp_payload), 32'd0);
         end else begin
            want = row_outputs_due.pop_front();
            if (rsp_payload.row_drive !== want.row_drive)
               report_mismatch("row_drive", 32'(rsp_payload.row_drive), 32'(want.row_drive));
            if (rsp_payload.column_drive !== want.column_drive)
               report_mismatch("column_drive", 32'(rsp_payload.column_drive),
                               32'(want.column_drive));
            if (rsp_payload.picture_number !== want.picture_number)
               report_mismatch("picture_number", 32'(rsp_payload.picture_number),
                               32'(want.picture_number));
            if (rsp_payload.picture_changed !== want.picture_changed)
               report_mismatch("picture_changed", 32'(rsp_payload.picture_changed),
                               32'(want.picture_changed));
         end
      end
   end

   // Watchdog: end the run when no channel moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      int         countdown;
      int         counted;
      int         pick;
      logic       btn;
      logic       btn_level;
      logic [7:0] pbyte;
      logic [4:0] pc_value;
      logic [7:0] fm_value;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Preload: every start entry and every pattern byte, so no tick ever
      // reads an unwritten location. Sprinkle end marks 8 to 41 bytes apart
      // so the windows wrap back to their picture start regularly.
      for (int s = 0; s < 16; s++)
         queue_request(OP_WRITE_START, 10'($urandom_range(0, 1023)), 8'($urandom), 4'(s),
                       1'($urandom));
      countdown = $urandom_range(7, 40);
      for (int a = 0; a < 1024; a++) begin
         if (countdown == 0) begin
            pbyte     = END_MARK;
            countdown = $urandom_range(7, 40);
         end else begin
            pbyte = 8'($urandom_range(0, 254));
            countdown--;
         end
         queue_request(OP_WRITE_PATTERN, 10'(a), pbyte, 4'($urandom), 1'($urandom));
      end
      wait_idle();

      // Directed part: all pictures, fastest scroll
      csr_write(CSR_PICTURE_COUNT, 8'd16);
      csr_write(CSR_FRAME_MS, 8'd1);
      // Extreme addresses and bytes; picture 0 starts on a window whose
      // last row already holds the end mark, slot 15 starts at the top
      // of the store so its window wraps around address zero.
      queue_request(OP_WRITE_PATTERN, 10'd0, 8'h00, 4'd0, 1'b0);
      queue_request(OP_WRITE_PATTERN, 10'd1023, 8'hff, 4'd15, 1'b1);
      queue_request(OP_WRITE_PATTERN, 10'(END_OFFSET), END_MARK, 4'd0, 1'b0);
      queue_request(OP_WRITE_START, 10'd0, 8'hff, 4'd0, 1'b0);
      queue_request(OP_WRITE_START, 10'd1023, 8'h00, 4'd15, 1'b1);
      queue_request(OP_UNDEFINED, 10'($urandom), 8'($urandom), 4'($urandom), 1'($urandom));
      // Three scans: button held between scans only (ignored), then a
      //   press at a scan end, then held (lockout).
      for (int k = 0; k < 21; k++) begin
         case (k / 7)
            0:       btn = (k % 7 != 6);
            1:       btn = (k % 7 == 6);
            default: btn = (k % 7 == 6) ? 1'b1 : 1'($urandom);
         endcase
         queue_request(OP_TICK, 10'($urandom), 8'($urandom), 4'($urandom), btn);
      end
      wait_idle();

      // Random phases, one register setting each, extremes included
      btn_level = 1'b0;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       begin pc_value = 5'd3;  fm_value = 8'd2;   end
            1:       begin pc_value = 5'd0;  fm_value = 8'd255; end
            2:       begin pc_value = 5'd31; fm_value = 8'd7;   end
            3:       begin pc_value = 5'd16; fm_value = 8'd1;   end
            4:       begin pc_value = 5'd5;  fm_value = 8'd0;   end
            5:       begin pc_value = 5'd17; fm_value = 8'd14;  end
            6:       begin pc_value = 5'($urandom); fm_value = 8'($urandom); end
            default: begin pc_value = 5'd1;  fm_value = 8'd125; end
         endcase
         if ($urandom_range(0, 1)) begin
            csr_write(CSR_PICTURE_COUNT, 8'(pc_value));
            csr_write(CSR_FRAME_MS, fm_value);
         end else begin
            csr_write(CSR_FRAME_MS, fm_value);
            csr_write(CSR_PICTURE_COUNT, 8'(pc_value));
         end
         if (phase == 2)
            csr_write(CSR_SPARE, 8'($urandom));
         // Drop all idling for the final phase
         quiet   = (phase == PHASES - 1);
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               pbyte = ($urandom_range(0, 7) == 0) ? END_MARK : 8'($urandom);
               queue_request(OP_WRITE_PATTERN, 10'($urandom), pbyte, 4'($urandom),
                             1'($urandom));
               counted++;
            end else if (pick < 12) begin
               queue_request(OP_WRITE_START, 10'($urandom), 8'($urandom), 4'($urandom),
                             1'($urandom));
               counted++;
            end else if (pick < 16) begin
               queue_request(OP_UNDEFINED, 10'($urandom), 8'($urandom), 4'($urandom),
                             1'($urandom));
            end else begin
               // Button only matters on the scan-ending tick: give it press,
               // hold and release runs there, and noise on the other rows.
               if (ticks_queued % ROWS == ROWS - 1) begin
                  if ($urandom_range(0, 2) == 0)
                     btn_level = !btn_level;
                  btn = btn_level;
               end else begin
                  btn = 1'($urandom);
               end
               queue_request(OP_TICK, 10'($urandom), 8'($urandom), 4'($urandom), btn);
               counted++;
            end
            // Pause the sender mid-phase until everything due has come back
            if (phase == 3 && counted == PHASE_ITEMS / 2 && pick >= 16)
               wait_idle();
         end
         wait_idle();
      end

      if (mismatch_count == 0 && row_outputs_due.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
